// ----- sv/rccb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rccb_pkg: shared types and constants of the range countdown counter bank
// Widths, request codes and saturation limits used by the core.
// ----------------------------------------------------------------------------
package rccb_pkg;
	localparam int Entries    = 1024;
	localparam int IdxBits    = 10;
	localparam int FieldBits  = 11;
	localparam int ReloadBits = 16;
	localparam int HitBits    = 32;
	localparam int SumBits    = 42;
	localparam logic [HitBits-1:0] HitMax = {HitBits{1'b1}};
	localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef struct packed {
		logic [ReloadBits-1:0] remaining;
		logic [ReloadBits-1:0] reload;
		logic [HitBits-1:0]    hits;
	} entry_t;
endpackage

// ----- sv/range_countdown_counter_bank_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_countdown_counter_bank_core: bank of 1024 reloading down-counters
// Load, range tick and range hit-sum query over one state memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries req_type, first_index,
//   last_index and reload_value. Output channel (out_valid/out_ready) carries
//   range_sum, produced only for queries. Config channel (cfg_valid/cfg_ready)
//   writes entry_count; write it only while the block is idle.
//   One entry memory (remaining, reload, hits) with a registered
//   read. A range operation sweeps the clipped range one entry per cycle,
//   pipelined read/modify/write. With the receiver ready, a tick passes
//   through sweep and drain and then frees the input; a query also holds
//   the input up to its result transaction. An empty range still passes
//   through both. A load or an unknown request type is handled in the
//   cycle it is accepted; one item is in flight at a time.
//   Consecutive tick writes target distinct addresses, so no forwarding is
//   needed inside one sweep; the next item starts only after the last write.
//   Reset clears control state and sets entry_count to 1024; the memory is
//   not cleared. When the receiver stalls, the result is held in the output
//   register and the next item waits until it is taken.
// ----------------------------------------------------------------------------
module range_countdown_counter_bank_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic [rccb_pkg::FieldBits-1:0]     first_index,
	input  logic [rccb_pkg::FieldBits-1:0]     last_index,
	input  logic [rccb_pkg::ReloadBits-1:0]    reload_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rccb_pkg::SumBits-1:0]       range_sum,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rccb_pkg::FieldBits-1:0]     cfg_data
);
	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_OUT} state_t;

	state_t                            state_q;
	logic [rccb_pkg::FieldBits-1:0]    entry_count_q;
	logic                              is_tick_q;
	logic [rccb_pkg::FieldBits-1:0]    cur_q;
	logic [rccb_pkg::FieldBits-1:0]    hi_q;
	logic [rccb_pkg::SumBits-1:0]      sum_q;
	logic                              rd_s1;
	logic [rccb_pkg::IdxBits-1:0]      addr_s1;
	rccb_pkg::entry_t                  mem [rccb_pkg::Entries];
	rccb_pkg::entry_t                  rdata_s1;
	logic                              we;
	logic [rccb_pkg::IdxBits-1:0]      waddr;
	rccb_pkg::entry_t                  wdata;
	logic                              rd_en;
	logic [rccb_pkg::IdxBits-1:0]      raddr;

	logic [rccb_pkg::FieldBits-1:0]    act_cnt, lo, hi;
	logic                              accept, load_ok;
	rccb_pkg::entry_t                  ticked;
	logic [rccb_pkg::SumBits-1:0]      sum_add;
	logic [rccb_pkg::SumBits:0]        sum_wide;

	assign act_cnt   = (entry_count_q > rccb_pkg::FieldBits'(rccb_pkg::Entries))
		? rccb_pkg::FieldBits'(rccb_pkg::Entries) : entry_count_q;
	assign lo        = (first_index == '0) ? rccb_pkg::FieldBits'(1) : first_index;
	assign hi        = (last_index > act_cnt) ? act_cnt : last_index;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign accept    = in_valid && in_ready;
	assign load_ok   = (first_index != '0) && (first_index <= act_cnt);
	assign out_valid = (state_q == ST_OUT);
	assign range_sum = sum_q;

	// reads: one per cycle while sweeping; index i maps to address i-1
	assign rd_en = (state_q == ST_SWEEP) && (cur_q <= hi_q);
	assign raddr = rccb_pkg::IdxBits'(cur_q - rccb_pkg::FieldBits'(1));

	// tick modify on registered read data
	always_comb begin
		ticked = rdata_s1;
		if (rdata_s1.remaining > rccb_pkg::ReloadBits'(1)) begin
			ticked.remaining = rdata_s1.remaining - rccb_pkg::ReloadBits'(1);
		end else begin
			ticked.remaining = rdata_s1.reload;
			if (rdata_s1.hits != rccb_pkg::HitMax) begin
				ticked.hits = rdata_s1.hits + rccb_pkg::HitBits'(1);
			end
		end
	end

	assign sum_add  = rccb_pkg::SumBits'(rdata_s1.hits);
	assign sum_wide = {1'b0, sum_q} + {1'b0, sum_add};

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = ticked;
		if (accept && (req_type == rccb_pkg::REQ_LOAD) && load_ok) begin
			we    = 1'b1;
			waddr = rccb_pkg::IdxBits'(first_index - rccb_pkg::FieldBits'(1));
			wdata = '{remaining: reload_value, reload: reload_value, hits: '0};
		end else if (rd_s1 && is_tick_q) begin
			we = 1'b1;
		end
	end

	// entry memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
		addr_s1 <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= rccb_pkg::FieldBits'(1024);
			is_tick_q     <= 1'b0;
			cur_q         <= '0;
			hi_q          <= '0;
			sum_q         <= '0;
			rd_s1         <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			// accumulate hits of the entry read last cycle
			if (rd_s1 && !is_tick_q) begin
				sum_q <= sum_wide[rccb_pkg::SumBits] ? rccb_pkg::SumMax
					: sum_wide[rccb_pkg::SumBits-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						entry_count_q <= cfg_data;
					end
					if (accept) begin
						cur_q     <= lo;
						hi_q      <= hi;
						sum_q     <= '0;
						is_tick_q <= (req_type == rccb_pkg::REQ_TICK);
						if (req_type == rccb_pkg::REQ_TICK
							|| req_type == rccb_pkg::REQ_QUERY) begin
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					// advance one entry per cycle
					if (cur_q <= hi_q) begin
						cur_q <= cur_q + rccb_pkg::FieldBits'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last write or accumulate already landed in the final sweep cycle
					state_q <= is_tick_q ? ST_IDLE : ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result held while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(range_sum))
		else $error("result changed while stalled");
	// no input taken while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while result pending");
	// a result only follows a query sweep
	a_out_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DRAIN) && !$past(is_tick_q))
		else $error("result without query");
	// memory reads only while sweeping
	a_read_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> state_q == ST_SWEEP && !in_ready)
		else $error("read outside sweep");
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for range_countdown_counter_bank_core
// Drives loads, range ticks and hit-sum queries through valid/ready channels
// with random gaps and stalls. A behavioural copy of the counter bank works
// out every query sum, and each returned sum is compared in order.
// ----------------------------------------------------------------------------
module testbench;
	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [1:0]                      req_type;
	logic [rccb_pkg::FieldBits-1:0]  first_index;
	logic [rccb_pkg::FieldBits-1:0]  last_index;
	logic [rccb_pkg::ReloadBits-1:0] reload_value;
	logic                            out_valid;
	logic                            out_ready;
	logic [rccb_pkg::SumBits-1:0]    range_sum;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [rccb_pkg::FieldBits-1:0]  cfg_data;

	range_countdown_counter_bank_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .first_index(first_index),
		.last_index(last_index), .reload_value(reload_value),
		.out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// Behavioural copy of the bank; index 0 unused
	logic [rccb_pkg::ReloadBits-1:0] mdl_remaining [0:rccb_pkg::Entries];
	logic [rccb_pkg::ReloadBits-1:0] mdl_reload    [0:rccb_pkg::Entries];
	logic [rccb_pkg::HitBits-1:0]    mdl_hits      [0:rccb_pkg::Entries];
	logic [rccb_pkg::FieldBits-1:0]  mdl_entry_count;

	logic [rccb_pkg::SumBits-1:0] expected_sums [$];
	int  error_count;
	int  query_count;
	int  tick_count;
	int  load_count;
	bit  hold_off;
	int  bank_sizes [5] = '{1, 2, 37, 1024, 0};

	function automatic int active_entries();
		return (mdl_entry_count > rccb_pkg::Entries) ? rccb_pkg::Entries
			: int'(mdl_entry_count);
	endfunction

	// Apply one transaction to the copy; push the sum for a query
	function automatic void apply_request(logic [1:0] rq, int fi, int la,
		logic [15:0] rv);
		int n;
		int lo;
		int hi;
		logic [rccb_pkg::SumBits-1:0] acc;
		n  = active_entries();
		lo = (fi < 1) ? 1 : fi;
		hi = (la > n) ? n : la;
		acc = '0;
		case (rq)
			rccb_pkg::REQ_LOAD: begin
				if (fi >= 1 && fi <= n) begin
					mdl_reload[fi]    = rv;
					mdl_remaining[fi] = rv;
					mdl_hits[fi]      = '0;
				end
			end
			rccb_pkg::REQ_TICK: begin
				for (int i = lo; i <= hi; i++) begin
					if (mdl_remaining[i] > 1) begin
						mdl_remaining[i]--;
					end else begin
						mdl_remaining[i] = mdl_reload[i];
						if (mdl_hits[i] != rccb_pkg::HitMax) mdl_hits[i]++;
					end
				end
			end
			rccb_pkg::REQ_QUERY: begin
				for (int i = lo; i <= hi; i++) begin
					if (acc > rccb_pkg::SumMax - {10'd0, mdl_hits[i]})
						acc = rccb_pkg::SumMax;
					else acc = acc + mdl_hits[i];
				end
				expected_sums.push_back(acc);
			end
			default: ;
		endcase
	endfunction

	// Receiver: random stalls, plus a long hold-off when asked
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end else if (!out_ready || out_valid) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
				if (gap == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (gap - 1) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Checker: compare each accepted sum with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_sums.size() == 0) begin
				$display("%0t: unexpected sum, expected none, actual %0d", $time, range_sum);
				error_count++;
			end else begin
				logic [rccb_pkg::SumBits-1:0] want;
				want = expected_sums.pop_front();
				if (range_sum !== want) begin
					$display("%0t: range_sum mismatch, expected %0d, actual %0d",
						$time, want, range_sum);
					error_count++;
				end
			end
		end
	end

	// Send one transaction, holding it until accepted; valid stays up after
	// acceptance so the next one can follow at once, and drops on a gap
	task automatic send_request(logic [1:0] rq, int fi, int la, logic [15:0] rv);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= rq;
		first_index  <= fi[rccb_pkg::FieldBits-1:0];
		last_index   <= la[rccb_pkg::FieldBits-1:0];
		reload_value <= rv;
		do @(posedge clk); while (!in_ready);
		apply_request(rq, fi, la, rv);
		case (rq)
			rccb_pkg::REQ_LOAD:  load_count++;
			rccb_pkg::REQ_TICK:  tick_count++;
			rccb_pkg::REQ_QUERY: query_count++;
			default: ;
		endcase
	endtask

	// Drain results, let the last sweep finish, then write entry_count
	task automatic write_entry_count(int value);
		in_valid <= 1'b0;
		wait (expected_sums.size() == 0);
		repeat (1100) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value[rccb_pkg::FieldBits-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mdl_entry_count = value[rccb_pkg::FieldBits-1:0];
	endtask

	// Load every active entry so no unwritten entry is ever read
	task automatic load_all(int n);
		for (int i = 1; i <= n; i++)
			send_request(rccb_pkg::REQ_LOAD, i, $urandom_range(0, 2047),
				16'($urandom_range(0, 7)));
	endtask

	typedef struct {
		logic [1:0]  rq;
		int          fi;
		int          la;
		logic [15:0] rv;
		bit          known;
		logic [rccb_pkg::SumBits-1:0] sum;
	} stim_row_t;

	// Directed rows with entry_count = 8, all entries loaded first
	stim_row_t directed_rows[] = '{
		'{rccb_pkg::REQ_QUERY, 1, 8, 16'd0, 1'b1, 42'd0},      // freshly loaded: no hits
		'{rccb_pkg::REQ_LOAD, 1, 0, 16'd0, 1'b0, 42'd0},        // zero period
		'{rccb_pkg::REQ_LOAD, 2, 0, 16'd1, 1'b0, 42'd0},
		'{rccb_pkg::REQ_LOAD, 3, 0, 16'hFFFF, 1'b0, 42'd0},     // widest period
		'{rccb_pkg::REQ_LOAD, 0, 0, 16'd5, 1'b0, 42'd0},        // index 0 ignored
		'{rccb_pkg::REQ_LOAD, 9, 0, 16'd5, 1'b0, 42'd0},        // beyond active count
		'{rccb_pkg::REQ_LOAD, 2047, 2047, 16'd5, 1'b0, 42'd0},
		'{rccb_pkg::REQ_TICK, 1, 3, 16'd0, 1'b0, 42'd0},
		'{rccb_pkg::REQ_QUERY, 1, 1, 16'd0, 1'b1, 42'd1},
		'{rccb_pkg::REQ_QUERY, 3, 3, 16'd0, 1'b1, 42'd0},
		'{rccb_pkg::REQ_TICK, 0, 2047, 16'hFFFF, 1'b0, 42'd0},  // clipped to whole bank
		'{rccb_pkg::REQ_QUERY, 0, 2047, 16'hFFFF, 1'b0, 42'd0},
		'{rccb_pkg::REQ_QUERY, 5, 4, 16'd0, 1'b1, 42'd0},       // first above last
		'{rccb_pkg::REQ_TICK, 6, 2, 16'd0, 1'b0, 42'd0},
		'{rccb_pkg::REQ_QUERY, 9, 2047, 16'd0, 1'b1, 42'd0},    // clipped to nothing
		'{rccb_pkg::REQ_NONE, 1, 8, 16'd3, 1'b0, 42'd0},        // unknown type, no result
		'{rccb_pkg::REQ_QUERY, 2, 2, 16'd0, 1'b1, 42'd2},
		'{rccb_pkg::REQ_QUERY, 1, 8, 16'd0, 1'b0, 42'd0}
	};

	initial begin
		int n;
		int fi;
		int la;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0; req_type = '0; first_index = '0; last_index = '0;
		reload_value = '0; cfg_valid = 1'b0; cfg_data = '0;
		error_count = 0; query_count = 0; tick_count = 0; load_count = 0;
		hold_off = 1'b0;
		mdl_entry_count = 11'd1024;
		for (int i = 0; i <= rccb_pkg::Entries; i++) begin
			mdl_remaining[i] = '0; mdl_reload[i] = '0; mdl_hits[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on a small bank; rows with a typed sum check it too
		write_entry_count(8);
		load_all(8);
		foreach (directed_rows[r]) begin
			if (directed_rows[r].known && directed_rows[r].rq == rccb_pkg::REQ_QUERY) begin
				apply_request(directed_rows[r].rq, directed_rows[r].fi,
					directed_rows[r].la, directed_rows[r].rv);
				if (expected_sums[$] !== directed_rows[r].sum) begin
					$display("%0t: typed sum row %0d, expected %0d, actual %0d",
						$time, r, directed_rows[r].sum, expected_sums[$]);
					error_count++;
				end
				void'(expected_sums.pop_back());
			end
			send_request(directed_rows[r].rq, directed_rows[r].fi,
				directed_rows[r].la, directed_rows[r].rv);
		end

		// Back pressure: the receiver holds off while queries keep coming
		hold_off = 1'b1;
		for (int k = 0; k < 4; k++)
			send_request(rccb_pkg::REQ_QUERY, 1, 8, 16'd0);

		// Random phases over several bank sizes, extremes among them
		foreach (bank_sizes[p]) begin
			n = bank_sizes[p];
			write_entry_count(n);
			if (n > 0 && n <= 37) load_all(n);
			else if (n == 1024) begin
				// load a small prefix and suffix, keep ranges inside them
				for (int i = 1; i <= 1024; i++)
					if (i <= 40 || i > 1016)
						send_request(rccb_pkg::REQ_LOAD, i, 0, 16'($urandom_range(0, 3)));
			end
			for (int k = 0; k < ((n == 0) ? 20 : (n == 1024) ? 60 : 90); k++) begin
				pick = $urandom_range(0, 9);
				if (n == 1024) begin
					if ($urandom_range(0, 1)) begin
						fi = $urandom_range(1, 40); la = $urandom_range(fi - 1, 40);
					end else begin
						fi = $urandom_range(1017, 1024); la = $urandom_range(fi, 2047);
					end
				end else begin
					fi = $urandom_range(0, 2047);
					la = $urandom_range(0, 2047);
					if ($urandom_range(0, 3) != 0) begin
						fi = $urandom_range(0, n + 1);
						la = $urandom_range(0, n + 2);
					end
				end
				if (pick < 2)
					send_request(rccb_pkg::REQ_LOAD,
						(n == 1024) ? fi : $urandom_range(0, 2047), la, 16'($urandom));
				else if (pick < 6)
					send_request(rccb_pkg::REQ_TICK, fi, la, 16'($urandom));
				else if (pick < 9)
					send_request(rccb_pkg::REQ_QUERY, fi, la, 16'($urandom));
				else
					send_request(rccb_pkg::REQ_NONE, fi, la, 16'($urandom));
			end
		end

		in_valid <= 1'b0;
		wait (expected_sums.size() == 0);
		repeat (1100) @(posedge clk);
		$display("Covered %0d loads, %0d range ticks, %0d queries", load_count,
			tick_count, query_count);
		$display("over bank sizes 8, 1, 2, 37, 1024 and 0, with a long output stall");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
